>>> rtl/csim_pkg.sv
package csim_pkg;

  // element and result words
  localparam int unsigned ElemW  = 16;
  localparam int unsigned ResW   = 16;
  localparam int unsigned FracW  = 15;

  // products and accumulators
  localparam int unsigned ProdW  = 2 * ElemW;
  localparam int unsigned SqW    = ProdW - 1;
  localparam int unsigned DotW   = 44;
  localparam int unsigned NormW  = 43;

  // final evaluation
  localparam int unsigned PW     = 2 * NormW;
  localparam int unsigned Q2W    = 2 * DotW;
  localparam int unsigned McW    = 2 * DotW - 1;
  localparam int unsigned QShift = 2 * FracW;
  localparam int unsigned RootW  = FracW + 1;
  localparam int unsigned KW     = $clog2(RootW);
  localparam int unsigned CntW   = $clog2(DotW);
  localparam int unsigned AddW   = 120;

endpackage

>>> rtl/csim_if.sv
interface csim_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [csim_pkg::ElemW-1:0] elem_a;
  logic signed [csim_pkg::ElemW-1:0] elem_b;
  logic                              last_pair;

  modport source (output valid, elem_a, elem_b, last_pair, input ready);
  modport sink   (input valid, elem_a, elem_b, last_pair, output ready);
endinterface

interface csim_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [csim_pkg::ResW-1:0] similarity;
  logic                             zero_norm;

  modport source (output valid, similarity, zero_norm, input ready);
  modport sink   (input valid, similarity, zero_norm, output ready);
endinterface

>>> rtl/cosine_similarity_engine_unit.sv
// Streaming cosine similarity of two Q1.15 vectors. Each input word carries one element
// pair and a last-pair flag; the block accumulates the dot product and both squared norms
// with saturation and, on the last pair, returns one word: the similarity in Q1.15,
// truncated toward zero and clamped to -32768..32767, with zero_norm set (and the
// similarity 0) when either norm is zero. Each pair's products are registered, then
// accumulated, before the next pair is taken. After a last pair, one 120-bit adder,
// shared under the sequencer, forms norm_a * norm_b in 43 shift-and-add steps and dot^2
// in 44 more, then finds the 16 result bits by restoring search, each bit by a trial
// add, a second add and a compare. With a zero norm the multiply and search are skipped.
// The result sits in an output register, so the next vector may start while it waits;
// the block only stalls when a second result is ready before the first is taken.
module cosine_similarity_engine_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  csim_in_if.sink    in_i,
  csim_out_if.source out_o
);

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;  // waiting for a word
  localparam logic [3:0] ST_ACC  = 4'd1;  // saturating accumulate
  localparam logic [3:0] ST_CHK  = 4'd2;  // zero-norm check, multiply setup
  localparam logic [3:0] ST_MULP = 4'd3;  // norm_a * norm_b
  localparam logic [3:0] ST_MULQ = 4'd4;  // |dot| * |dot|
  localparam logic [3:0] ST_TRYA = 4'd5;  // trial: s + P*4^k
  localparam logic [3:0] ST_TRYB = 4'd6;  // trial: + r*P*2^(k+1)
  localparam logic [3:0] ST_TRYC = 4'd7;  // compare, update r*P
  localparam logic [3:0] ST_FIN  = 4'd8;  // load output register

  localparam int unsigned DotW = csim_pkg::DotW;
  localparam int unsigned NormW = csim_pkg::NormW;
  localparam int unsigned AddW = csim_pkg::AddW;
  localparam int unsigned RootW = csim_pkg::RootW;

  logic [3:0] state_q, state_d;

  // registered element products
  logic signed [csim_pkg::ProdW-1:0] prod_ab_q, prod_ab_d;
  logic [csim_pkg::SqW-1:0]          prod_aa_q, prod_aa_d;
  logic [csim_pkg::SqW-1:0]          prod_bb_q, prod_bb_d;
  logic                              last_q, last_d;

  // accumulators
  logic signed [DotW-1:0] dot_q, dot_d;
  logic [NormW-1:0]       na_q, na_d;
  logic [NormW-1:0]       nb_q, nb_d;

  // shift-and-add multiply
  logic [csim_pkg::McW-1:0]  mcand_q, mcand_d;
  logic [DotW-1:0]           mplier_q, mplier_d;
  logic [csim_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [csim_pkg::PW-1:0]   p_q, p_d;
  logic [csim_pkg::Q2W-1:0]  q2_q, q2_d;

  // root search: acc holds the running sum / trial value
  logic [AddW-1:0]         acc_q, acc_d;
  logic [AddW-1:0]         s_q, s_d;     // r^2 * P
  logic [AddW-1:0]         pk_q, pk_d;   // P * 4^k
  logic [AddW-1:0]         rpk_q, rpk_d; // r * P * 2^(k+1)
  logic [RootW-1:0]        root_q, root_d;
  logic                    top_q, top_d; // r reached 32768
  logic [csim_pkg::KW-1:0] k_q, k_d;
  logic                    zero_q, zero_d;

  // output register
  logic                             out_valid_q, out_valid_d;
  logic signed [csim_pkg::ResW-1:0] out_sim_q, out_sim_d;
  logic                             out_zero_q, out_zero_d;

  // shared adder
  logic [AddW-1:0] add_a, add_b, add_sum;

  logic signed [csim_pkg::ProdW-1:0] mul_ab, mul_aa, mul_bb;
  logic signed [DotW:0]              dot_sum_w;
  logic [NormW:0]                    na_sum_w, nb_sum_w;
  logic [DotW-1:0]                   dot_mag;
  logic [AddW-1:0]                   q2_scaled;
  logic                              fit;
  logic                              out_free;
  logic signed [csim_pkg::ResW-1:0]  sim_val;

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.similarity = out_sim_q;
  assign out_o.zero_norm  = out_zero_q;

  assign mul_ab = in_i.elem_a * in_i.elem_b;
  assign mul_aa = in_i.elem_a * in_i.elem_a;
  assign mul_bb = in_i.elem_b * in_i.elem_b;

  // saturating sums, one guard bit each
  assign dot_sum_w = {dot_q[DotW-1], dot_q}
                   + {{(DotW + 1 - csim_pkg::ProdW){prod_ab_q[csim_pkg::ProdW-1]}}, prod_ab_q};
  assign na_sum_w  = {1'b0, na_q} + (NormW + 1)'(prod_aa_q);
  assign nb_sum_w  = {1'b0, nb_q} + (NormW + 1)'(prod_bb_q);

  // magnitude of the dot sum; the most negative value maps to 2^43 and still fits
  assign dot_mag = dot_q[DotW-1] ? (~dot_q + DotW'(1)) : dot_q;

  // dot^2 * 2^30 is what r^2 * P is held against
  assign q2_scaled = AddW'({q2_q, {csim_pkg::QShift{1'b0}}});
  assign fit       = (acc_q <= q2_scaled) && !top_q;

  assign out_free = !out_valid_q || out_o.ready;

  // result from root and sign; a positive root of 32768 clamps
  always_comb begin
    if (zero_q) begin
      sim_val = '0;
    end else if (dot_q[DotW-1]) begin
      sim_val = csim_pkg::ResW'(-$signed({1'b0, root_q}));
    end else if (root_q[RootW-1]) begin
      sim_val = {1'b0, {(csim_pkg::ResW - 1){1'b1}}};
    end else begin
      sim_val = csim_pkg::ResW'(root_q);
    end
  end

  // operand select for the shared adder
  always_comb begin
    unique case (state_q) inside
      ST_MULP, ST_MULQ: begin
        add_a = acc_q;
        add_b = mplier_q[0] ? AddW'(mcand_q) : '0;
      end
      ST_TRYA: begin
        add_a = s_q;
        add_b = pk_q;
      end
      ST_TRYB: begin
        add_a = acc_q;
        add_b = rpk_q;
      end
      ST_TRYC: begin
        add_a = rpk_q;
        add_b = {pk_q[AddW-2:0], 1'b0};
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // sequencer
  always_comb begin
    state_d     = state_q;
    prod_ab_d   = prod_ab_q;
    prod_aa_d   = prod_aa_q;
    prod_bb_d   = prod_bb_q;
    last_d      = last_q;
    dot_d       = dot_q;
    na_d        = na_q;
    nb_d        = nb_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    q2_d        = q2_q;
    acc_d       = acc_q;
    s_d         = s_q;
    pk_d        = pk_q;
    rpk_d       = rpk_q;
    root_d      = root_q;
    top_d       = top_q;
    k_d         = k_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_sim_d   = out_sim_q;
    out_zero_d  = out_zero_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          prod_ab_d = mul_ab;
          prod_aa_d = mul_aa[csim_pkg::SqW-1:0];
          prod_bb_d = mul_bb[csim_pkg::SqW-1:0];
          last_d    = in_i.last_pair;
          state_d   = ST_ACC;
        end
      end

      ST_ACC: begin
        if (dot_sum_w[DotW] != dot_sum_w[DotW-1]) begin
          dot_d = dot_sum_w[DotW] ? {1'b1, {(DotW - 1){1'b0}}} : {1'b0, {(DotW - 1){1'b1}}};
        end else begin
          dot_d = dot_sum_w[DotW-1:0];
        end
        na_d    = na_sum_w[NormW] ? '1 : na_sum_w[NormW-1:0];
        nb_d    = nb_sum_w[NormW] ? '1 : nb_sum_w[NormW-1:0];
        state_d = last_q ? ST_CHK : ST_IDLE;
      end

      ST_CHK: begin
        if (na_q == '0 || nb_q == '0) begin
          zero_d  = 1'b1;
          state_d = ST_FIN;
        end else begin
          zero_d   = 1'b0;
          acc_d    = '0;
          mcand_d  = csim_pkg::McW'(na_q);
          mplier_d = DotW'(nb_q);
          cnt_d    = '0;
          state_d  = ST_MULP;
        end
      end

      ST_MULP: begin
        acc_d    = add_sum;
        mcand_d  = {mcand_q[csim_pkg::McW-2:0], 1'b0};
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + csim_pkg::CntW'(1);
        if (cnt_q == csim_pkg::CntW'(NormW - 1)) begin
          p_d      = add_sum[csim_pkg::PW-1:0];
          acc_d    = '0;
          mcand_d  = csim_pkg::McW'(dot_mag);
          mplier_d = dot_mag;
          cnt_d    = '0;
          state_d  = ST_MULQ;
        end
      end

      ST_MULQ: begin
        acc_d    = add_sum;
        mcand_d  = {mcand_q[csim_pkg::McW-2:0], 1'b0};
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + csim_pkg::CntW'(1);
        if (cnt_q == csim_pkg::CntW'(DotW - 1)) begin
          q2_d    = add_sum[csim_pkg::Q2W-1:0];
          s_d     = '0;
          rpk_d   = '0;
          pk_d    = AddW'({p_q, {csim_pkg::QShift{1'b0}}});
          k_d     = csim_pkg::KW'(RootW - 1);
          top_d   = 1'b0;
          state_d = ST_TRYA;
        end
      end

      ST_TRYA: begin
        acc_d   = add_sum;
        state_d = ST_TRYB;
      end

      ST_TRYB: begin
        acc_d   = add_sum;
        state_d = ST_TRYC;
      end

      ST_TRYC: begin
        // (r + 2^k)^2 P = r^2 P + r P 2^(k+1) + P 4^k, kept exact by shifting down
        if (fit) begin
          s_d = acc_q;
        end
        rpk_d  = (fit ? add_sum : rpk_q) >> 1;
        pk_d   = pk_q >> 2;
        root_d = {root_q[RootW-2:0], fit};
        if (k_q == csim_pkg::KW'(RootW - 1)) begin
          top_d = fit;
        end
        if (k_q == '0) begin
          state_d = ST_FIN;
        end else begin
          k_d     = k_q - csim_pkg::KW'(1);
          state_d = ST_TRYA;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sim_d   = sim_val;
          out_zero_d  = zero_q;
          dot_d       = '0;
          na_d        = '0;
          nb_d        = '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      dot_q       <= '0;
      na_q        <= '0;
      nb_q        <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      top_q       <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      dot_q       <= dot_d;
      na_q        <= na_d;
      nb_q        <= nb_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      top_q       <= top_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_ab_q  <= prod_ab_d;
    prod_aa_q  <= prod_aa_d;
    prod_bb_q  <= prod_bb_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    p_q        <= p_d;
    q2_q       <= q2_d;
    acc_q      <= acc_d;
    s_q        <= s_d;
    pk_q       <= pk_d;
    rpk_q      <= rpk_d;
    root_q     <= root_d;
    out_sim_q  <= out_sim_d;
    out_zero_q <= out_zero_d;
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import csim_pkg::*;

  // accumulator limits, as the block saturates them after every add
  localparam longint DotMaxL  = (longint'(1) <<< (DotW - 1)) - 1;
  localparam longint DotMinL  = -DotMaxL - 1;
  localparam longint NormMaxL = (longint'(1) << NormW) - 1;

  // full-scale pairs per long vector
  localparam int unsigned LongLen = 32;

  // one result word as the block returns it
  typedef struct packed {
    logic signed [ResW-1:0] similarity;
    logic                   zero_norm;
  } sim_word_t;

  // shapes of random vector pairs
  typedef enum int unsigned {
    VEC_WIDE,
    VEC_SMALL,
    VEC_ALIGNED,
    VEC_OPPOSED,
    VEC_NEAR,
    VEC_ZERO_A,
    VEC_ZERO_B
  } vec_kind_e;

  logic clk_i;
  logic rst_ni;

  csim_in_if  in_if ();
  csim_out_if out_if ();

  cosine_similarity_engine_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predicted accumulator state
  logic signed [DotW-1:0] dot_acc;
  logic [NormW-1:0]       norm_a_acc;
  logic [NormW-1:0]       norm_b_acc;

  // similarity words still owed by the block, oldest first
  sim_word_t sim_owed_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned pair_count;
  int unsigned vector_count;
  int unsigned checked_count;
  int unsigned fail_count;

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // add one element pair into the predicted sums, saturating like the block
  function automatic void accumulate_pair(input logic signed [ElemW-1:0] a,
                                          input logic signed [ElemW-1:0] b);
    longint d;
    longint na;
    longint nb;
    d  = longint'(dot_acc) + longint'(a) * longint'(b);
    na = longint'(norm_a_acc) + longint'(a) * longint'(a);
    nb = longint'(norm_b_acc) + longint'(b) * longint'(b);
    if (d > DotMaxL) d = DotMaxL;
    if (d < DotMinL) d = DotMinL;
    if (na > NormMaxL) na = NormMaxL;
    if (nb > NormMaxL) nb = NormMaxL;
    dot_acc    = d[DotW-1:0];
    norm_a_acc = na[NormW-1:0];
    norm_b_acc = nb[NormW-1:0];
  endfunction

  // close the vector: exact integer cosine, then clear the sums
  function automatic sim_word_t finish_vector();
    sim_word_t    w;
    logic [127:0] q;
    logic [127:0] q2;
    logic [127:0] p;
    longint       mag;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    logic         neg;
    w.similarity = '0;
    w.zero_norm  = 1'b0;
    if (norm_a_acc == '0 || norm_b_acc == '0) begin
      w.zero_norm = 1'b1;
    end else begin
      neg = dot_acc[DotW-1];
      mag = neg ? -longint'(dot_acc) : longint'(dot_acc);
      q   = 128'(mag) << FracW;
      q2  = q * q;
      p   = 128'(norm_a_acc) * 128'(norm_b_acc);
      // largest r up to 2^15 with r^2 * na * nb <= (dot * 2^15)^2
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (p * (128'(mid) * 128'(mid)) <= q2) lo = mid;
        else hi = mid - 1;
      end
      if (neg) w.similarity = ResW'(0 - lo);
      else w.similarity = ResW'((lo > 32767) ? 32767 : lo);
    end
    dot_acc    = '0;
    norm_a_acc = '0;
    norm_b_acc = '0;
    return w;
  endfunction

  // drive one pair word and wait for it to be taken; valid stays high across
  // back-to-back words so it is never lowered and raised in one step
  task automatic send_pair(input logic signed [ElemW-1:0] a,
                           input logic signed [ElemW-1:0] b,
                           input logic                    last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.elem_a    <= a;
    in_if.elem_b    <= b;
    in_if.last_pair <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pair_count++;
    accumulate_pair(a, b);
    if (last) begin
      sim_owed_q.push_back(finish_vector());
      vector_count++;
    end
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each returned word with the oldest prediction
  always @(posedge clk_i) begin : result_check
    sim_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sim_owed_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got similarity %0d zero_norm %0b",
                 $time, out_if.similarity, out_if.zero_norm);
        fail_count++;
      end else begin
        want = sim_owed_q.pop_front();
        checked_count++;
        if (out_if.similarity !== want.similarity) begin
          $display("%0t: similarity mismatch, expected %0d, got %0d",
                   $time, want.similarity, out_if.similarity);
          fail_count++;
        end
        if (out_if.zero_norm !== want.zero_norm) begin
          $display("%0t: zero_norm mismatch, expected %0b, got %0b",
                   $time, want.zero_norm, out_if.zero_norm);
          fail_count++;
        end
      end
    end
  end

  // single-pair vectors at the corners of the element range and near zero; each
  // quotient is +1 or -1, and the +1 ones must be clamped
  task automatic test_extremes();
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    send_pair(-16'sd32768, -16'sd32768, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    send_pair(16'sd32767, -16'sd32768, 1'b1);
    send_pair(16'sd1, -16'sd1, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(-16'sd1, 16'sd3, 1'b1);
  endtask

  // either norm zero: similarity forced to 0 with the flag set
  task automatic test_zero_norm();
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd0, -16'sd32768, 1'b1);
    send_pair(16'sd32767, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sd7, 1'b0);
    send_pair(16'sd0, -16'sd7, 1'b1);
  endtask

  // short multi-pair vectors: orthogonal, nearly opposite, mixed signs
  task automatic test_short_vectors();
    send_pair(16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd1, 1'b1);
    send_pair(16'sd3, 16'sd4, 1'b0);
    send_pair(16'sd4, -16'sd3, 1'b1);
    send_pair(16'sd32767, -16'sd32768, 1'b0);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    send_pair(16'sd100, 16'sd100, 1'b0);
    send_pair(16'sd200, -16'sd50, 1'b0);
    send_pair(-16'sd300, 16'sd10, 1'b1);
  endtask

  // long full-scale vectors: large positive and negative dot sums and
  // large norms
  task automatic test_long_vectors();
    int unsigned i;
    for (i = 0; i < LongLen; i++) begin
      send_pair(-16'sd32768, -16'sd32768, i == LongLen - 1);
    end
    for (i = 0; i < LongLen; i++) begin
      send_pair(-16'sd32768, 16'sd32767, i == LongLen - 1);
    end
  endtask

  // one random vector pair of a random shape; returns its length
  task automatic send_random_vector(output int unsigned len);
    vec_kind_e               kind;
    int unsigned             pick;
    int unsigned             i;
    logic signed [ElemW-1:0] a;
    logic signed [ElemW-1:0] b;
    pick = $urandom_range(99);
    if (pick < 40) kind = VEC_WIDE;
    else if (pick < 55) kind = VEC_SMALL;
    else if (pick < 67) kind = VEC_ALIGNED;
    else if (pick < 77) kind = VEC_OPPOSED;
    else if (pick < 92) kind = VEC_NEAR;
    else if (pick < 96) kind = VEC_ZERO_A;
    else kind = VEC_ZERO_B;
    // mostly short vectors, a few longer ones
    len = ($urandom_range(9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 48);
    for (i = 0; i < len; i++) begin
      a = ElemW'($urandom);
      b = ElemW'($urandom);
      case (kind)
        VEC_SMALL: begin
          a = ElemW'(int'($urandom_range(16)) - 8);
          b = ElemW'(int'($urandom_range(16)) - 8);
        end
        VEC_ALIGNED: b = a;
        VEC_OPPOSED: b = -a;
        VEC_NEAR:    b = ElemW'(int'(a) + int'($urandom_range(64)) - 32);
        VEC_ZERO_A:  a = '0;
        VEC_ZERO_B:  b = '0;
        default: ;
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  // random vectors under three idle patterns: sender-light, receiver-light, none
  task automatic test_random();
    int unsigned phase;
    int unsigned sent;
    int unsigned len;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < 270) begin
        send_random_vector(len);
        sent += len;
      end
    end
  endtask

  initial begin : main
    int unsigned drain;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.elem_a    = '0;
    in_if.elem_b    = '0;
    in_if.last_pair = 1'b0;
    out_if.ready    = 1'b0;
    dot_acc         = '0;
    norm_a_acc      = '0;
    norm_b_acc      = '0;
    send_idle_pct   = 15;
    recv_idle_pct   = 47;
    pair_count      = 0;
    vector_count    = 0;
    checked_count   = 0;
    fail_count      = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_zero_norm();
    test_short_vectors();
    test_long_vectors();
    test_random();
    in_if.valid <= 1'b0;

    // let the last evaluations finish, bounded
    drain = 0;
    while (sim_owed_q.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    if (sim_owed_q.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, sim_owed_q.size());
      fail_count++;
    end
    repeat (200) @(posedge clk_i);

    $display("run covered %0d vectors from %0d element pairs, incl. long full-scale ones",
             vector_count, pair_count);
    $display("%0d result words checked, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15000000;
    $display("timeout with %0d result words outstanding", sim_owed_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> cosine_similarity_engine_unit.f
rtl/csim_pkg.sv
rtl/csim_if.sv
rtl/cosine_similarity_engine_unit.sv
sim/tb_top.sv
